FILE: rtl/atm_pkg.sv
package atm_pkg;

    // fitted curve constants, units of 2^-16
    localparam logic [17:0] CURVE_A = 18'd164495;
    localparam logic [17:0] CURVE_B = 18'd1966;
    localparam logic [17:0] CURVE_C = 18'd159252;
    localparam logic [17:0] CURVE_D = 18'd38666;
    localparam logic [17:0] CURVE_E = 18'd9175;

    localparam int LINEAR_WIDTH = 24;
    localparam int CODE_WIDTH   = 8;
    localparam int X_WIDTH      = 21;
    localparam logic [X_WIDTH-1:0] X_LIMIT = 21'h100000;
    localparam int QUOT_BITS    = 16;
    localparam int WIDE_WIDTH   = 60;

    // stage 0 curve terms, stage 1 products, stage 2 sums, stage 3 compare,
    // 16 divide stages, 4 code search stages
    localparam int PIPE_STAGES  = 24;
    localparam int DIV_BASE     = 3;
    localparam int SEARCH_BASE  = DIV_BASE + QUOT_BITS;

endpackage

FILE: rtl/atm_channel.sv
module atm_channel #(
    parameter int INPUT_FRAC_BITS = 16,
    parameter int LUT_INDEX_BITS  = 12
) (
    input  logic                                  i_clk,
    input  logic [atm_pkg::PIPE_STAGES-1:0]       i_en,
    input  logic [atm_pkg::LINEAR_WIDTH-1:0]      i_linear,
    output logic [atm_pkg::CODE_WIDTH-1:0]        o_code
);

    localparam int XW = atm_pkg::X_WIDTH;
    localparam int WW = atm_pkg::WIDE_WIDTH;
    localparam int QB = atm_pkg::QUOT_BITS;
    localparam int L  = LUT_INDEX_BITS;

    typedef logic [L:0] t_thr_tab [256];

    // smallest index whose gamma code reaches c
    function automatic t_thr_tab build_thr();
        t_thr_tab     tab;
        logic [351:0] rhs;
        logic [351:0] lhs;
        int           lo;
        int           hi;
        int           mid;
        tab[0] = '0;
        for (int c = 1; c < 256; c++) begin
            rhs = 352'd1;
            for (int k = 0; k < 22; k++) rhs = rhs * c;
            rhs = rhs << (10 * L);
            lo = 0;
            hi = 1 << L;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                lhs = 352'd1;
                for (int k = 0; k < 10; k++) lhs = lhs * mid;
                lhs = lhs << 176;
                if (lhs >= rhs) hi = mid;
                else lo = mid + 1;
            end
            tab[c] = (L+1)'(lo);
        end
        return tab;
    endfunction

    localparam t_thr_tab THR = build_thr();

    // input scaling to 16 fraction bits and clamp
    logic [31:0] w_xw;
    logic [XW-1:0] w_x;
    generate
        if (INPUT_FRAC_BITS >= 16) begin : g_shr
            assign w_xw = {8'd0, i_linear} >> (INPUT_FRAC_BITS - 16);
        end else begin : g_shl
            assign w_xw = {8'd0, i_linear} << (16 - INPUT_FRAC_BITS);
        end
    endgenerate
    assign w_x = (w_xw > 32'(atm_pkg::X_LIMIT)) ? atm_pkg::X_LIMIT : w_xw[XW-1:0];

    // stage 0
    logic [XW-1:0] r_x0;
    logic [38:0]   r_tn, r_td;
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x0 <= w_x;
            r_tn <= 39'(atm_pkg::CURVE_A * w_x) + {5'd0, atm_pkg::CURVE_B, 16'd0};
            r_td <= 39'(atm_pkg::CURVE_C * w_x) + {5'd0, atm_pkg::CURVE_D, 16'd0};
        end
    end

    // stage 1: products split in two halves
    logic [40:0] r_pn_lo, r_pd_lo;
    logic [39:0] r_pn_hi, r_pd_hi;
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_pn_lo <= 41'(r_x0 * r_tn[19:0]);
            r_pn_hi <= 40'(r_x0 * r_tn[38:20]);
            r_pd_lo <= 41'(r_x0 * r_td[19:0]);
            r_pd_hi <= 40'(r_x0 * r_td[38:20]);
        end
    end

    // stage 2
    logic [WW-1:0] r_num, r_den2;
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_num  <= WW'(r_pn_lo) + (WW'(r_pn_hi) << 20);
            r_den2 <= WW'(r_pd_lo) + (WW'(r_pd_hi) << 20)
                    + (WW'(atm_pkg::CURVE_E) << 32);
        end
    end

    // divide stages, index 0 holds the saturation check
    // the remainder stays below the denominator, so WW bits hold it
    logic [WW-1:0] r_rem [0:QB-1];
    logic [WW-1:0] r_den [0:QB-1];
    logic [QB-1:0] r_quo [0:QB];
    logic          r_sat [0:QB];

    always_ff @(posedge i_clk) begin
        if (i_en[atm_pkg::DIV_BASE]) begin
            r_rem[0] <= r_num;
            r_den[0] <= r_den2;
            r_quo[0] <= '0;
            r_sat[0] <= (r_num >= r_den2);
        end
    end

    genvar k;
    generate
        for (k = 0; k < QB; k++) begin : g_div
            logic [WW:0] w_sh;
            logic [WW:0] w_diff;
            logic        w_ge;
            assign w_sh   = {r_rem[k], 1'b0};
            assign w_diff = w_sh - {1'b0, r_den[k]};
            assign w_ge   = (w_sh >= {1'b0, r_den[k]});
            always_ff @(posedge i_clk) begin
                if (i_en[atm_pkg::DIV_BASE + k + 1]) begin
                    r_quo[k+1] <= {r_quo[k][QB-2:0], w_ge};
                    r_sat[k+1] <= r_sat[k];
                end
            end
            // the last step needs no remainder
            if (k < QB - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (i_en[atm_pkg::DIV_BASE + k + 1]) begin
                        r_rem[k+1] <= w_ge ? w_diff[WW-1:0] : w_sh[WW-1:0];
                        r_den[k+1] <= r_den[k];
                    end
                end
            end
        end
    endgenerate

    // curve result of one or more reads as all ones
    logic [QB-1:0] w_tone;
    assign w_tone = r_sat[QB] ? '1 : r_quo[QB];

    // code search: two code bits per stage against the threshold table
    logic [7:0]   r_code [1:4];
    logic [L-1:0] r_idx  [1:3];
    logic [L-1:0] w_idx0;
    assign w_idx0 = w_tone[QB-1 -: L];

    genvar j;
    generate
        for (j = 1; j <= 4; j++) begin : g_srch
            logic [7:0]   w_prev, w_c1, w_c2, w_cand1, w_cand2;
            logic [L-1:0] w_pidx;
            if (j == 1) begin : g_first
                assign w_prev = 8'd0;
                assign w_pidx = w_idx0;
            end else begin : g_next
                assign w_prev = r_code[j-1];
                assign w_pidx = r_idx[j-1];
            end
            always_comb begin
                w_cand1 = w_prev | (8'd1 << (9 - 2*j));
                w_c1    = (THR[w_cand1] <= {1'b0, w_pidx}) ? w_cand1 : w_prev;
                w_cand2 = w_c1 | (8'd1 << (8 - 2*j));
                w_c2    = (THR[w_cand2] <= {1'b0, w_pidx}) ? w_cand2 : w_c1;
            end
            always_ff @(posedge i_clk) begin
                if (i_en[atm_pkg::SEARCH_BASE + j]) begin
                    r_code[j] <= w_c2;
                end
            end
            if (j < 4) begin : g_idx
                always_ff @(posedge i_clk) begin
                    if (i_en[atm_pkg::SEARCH_BASE + j]) begin
                        r_idx[j] <= w_pidx;
                    end
                end
            end
        end
    endgenerate

    assign o_code = r_code[4];

endmodule

FILE: rtl/aces_tone_map_gamma_encode.sv
// aces filmic tone map and gamma encode, one rgb pixel per transaction
// slave channel s_axis: one pixel of three 24-bit unsigned linear values with
// INPUT_FRAC_BITS fraction bits; master channel m_axis: three 8-bit codes
// each channel runs the fitted aces curve with 16 fraction bits, clamps to
// [0,1] and reads a gamma 1/2.2 code from the top LUT_INDEX_BITS of the result
// m_axis_tvalid rises once an accepted pixel reaches the last stage
// throughput is one pixel per cycle while m_axis_tready holds; nothing links one pixel to the next
// the pipeline is 24 register stages: curve terms, split products, sums,
// a saturation compare, 16 restoring divide steps (one quotient bit each)
// and 4 steps of a binary search over a 256-entry threshold table
// each stage holds a valid bit and moves when it is empty or the stage after it
// moves, so bubbles close up and input is taken while a result waits
// when the receiver stalls the pipeline fills and s_axis_tready falls only
// once all 24 stages hold a pixel; nothing is lost or repeated
// reset clears all valid bits; no pixel is in flight afterwards
module aces_tone_map_gamma_encode #(
    parameter int INPUT_FRAC_BITS = 16,
    parameter int LUT_INDEX_BITS  = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // red_linear, green_linear, blue_linear
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // red_code, green_code, blue_code
);

    localparam int N = atm_pkg::PIPE_STAGES;

    logic [N-1:0] r_valid, n_valid;
    logic [N-1:0] w_en;

    always_comb begin
        w_en[N-1] = !r_valid[N-1] || m_axis_tready;
        for (int s = N - 2; s >= 0; s--) w_en[s] = !r_valid[s] || w_en[s+1];
        n_valid[0] = w_en[0] ? s_axis_tvalid : r_valid[0];
        for (int s = 1; s < N; s++) n_valid[s] = w_en[s] ? r_valid[s-1] : r_valid[s];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_valid[N-1];

    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_ch
            atm_channel #(
                .INPUT_FRAC_BITS(INPUT_FRAC_BITS),
                .LUT_INDEX_BITS (LUT_INDEX_BITS)
            ) u_ch (
                .i_clk   (i_clk),
                .i_en    (w_en),
                .i_linear(s_axis_tdata[24*c +: 24]),
                .o_code  (m_axis_tdata[8*c +: 8])
            );
        end
    endgenerate

    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[0] |-> s_axis_tready)
        else $error("input refused with an empty first stage");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_valid) && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken into a full stalled pipeline");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_valid[0])
        else $error("accepted pixel missing from first stage");

endmodule

FILE: verif/testbench.sv
module testbench;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } codes_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // red_linear, green_linear, blue_linear
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // red_code, green_code, blue_code

    logic [71:0] pending_pixels[$];
    codes_t      expected_codes[$];
    logic [7:0]  gamma_table[4096];
    int          n_errors;
    int          n_sent;
    int          n_received;
    int          n_queued;
    int          send_gap;
    int          recv_gap;
    bit          hold_off;
    bit          late_phase;

    aces_tone_map_gamma_encode u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // largest code c with c^22 * 2^120 <= idx^10 * 2^176, for 12 index bits
    task automatic build_gamma_table();
        logic [319:0] code_pow[256];
        logic [319:0] rhs;
        logic [7:0]   code;
        logic [7:0]   cand;
        for (int c = 0; c < 256; c++) begin
            code_pow[c] = 320'd1;
            for (int k = 0; k < 22; k++) code_pow[c] = code_pow[c] * c;
            code_pow[c] = code_pow[c] << 120;
        end
        for (int idx = 0; idx < 4096; idx++) begin
            rhs = 320'd1;
            for (int k = 0; k < 10; k++) rhs = rhs * idx;
            rhs = rhs << 176;
            code = 8'd0;
            for (int b = 7; b >= 0; b--) begin
                cand = code | (8'd1 << b);
                if (code_pow[cand] <= rhs) code = cand;
            end
            gamma_table[idx] = code;
        end
    endtask

    function automatic logic [7:0] encode_channel(logic [23:0] raw);
        logic [63:0] x;
        logic [63:0] num;
        logic [63:0] den;
        logic [79:0] quot;
        logic [15:0] mapped;
        x = {40'd0, raw};
        if (x > 64'h100000) x = 64'h100000;
        num = x * (64'd164495 * x + (64'd1966 << 16));
        den = x * (64'd159252 * x + (64'd38666 << 16)) + (64'd9175 << 32);
        if (num >= den) begin
            mapped = 16'hFFFF;
        end else begin
            quot = ({16'd0, num} << 16) / {16'd0, den};
            mapped = quot[15:0];
        end
        return gamma_table[mapped[15:4]];
    endfunction

    function automatic codes_t predict_codes(logic [71:0] pixel);
        codes_t c;
        c.red   = encode_channel(pixel[23:0]);
        c.green = encode_channel(pixel[47:24]);
        c.blue  = encode_channel(pixel[71:48]);
        return c;
    endfunction

    task automatic report(string what, int got, int want);
        n_errors++;
        $display("mismatch at output %0d: %s got %0d expected %0d", n_received, what, got, want);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_codes.push_back(predict_codes(s_axis_tdata));
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (!late_phase && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(0, 16);
                    s_axis_tvalid <= 1'b0;
                end else if (pending_pixels.size() > 0) begin
                    s_axis_tdata <= pending_pixels.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver with stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (!late_phase && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(0, 16);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !hold_off;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        codes_t got;
        codes_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_codes.size() == 0) begin
                report("unexpected output transaction", m_axis_tdata, 0);
            end else begin
                want = expected_codes.pop_front();
                if (got.red !== want.red) report("red_code", got.red, want.red);
                if (got.green !== want.green) report("green_code", got.green, want.green);
                if (got.blue !== want.blue) report("blue_code", got.blue, want.blue);
            end
            n_received++;
        end
    end

    always @(posedge i_clk) late_phase <= (n_queued > 0 && pending_pixels.size() < 100);

    // long receiver hold-off so the pipeline fills and stalls its input
    initial begin
        hold_off = 1'b0;
        wait (n_sent >= 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (150) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        logic [23:0] chan[3];
        logic [23:0] corners[14];
        int          kind;
        n_errors = 0;
        n_sent = 0;
        n_received = 0;
        n_queued = 0;
        send_gap = 0;
        recv_gap = 0;
        late_phase = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        build_gamma_table();

        // zero, full scale, around 1.0 and 16.0, tiny values, curve saturation
        corners = '{24'h000000, 24'hFFFFFF, 24'h000001, 24'h00000F, 24'h010000,
                    24'h00FFFF, 24'h0FFFFF, 24'h100000, 24'h100001, 24'h0A0000,
                    24'h040000, 24'h008000, 24'hAAAAAA, 24'h555555};
        foreach (corners[i]) begin
            pending_pixels.push_back({corners[i], corners[(i + 5) % 14], corners[(i + 9) % 14]});
        end
        pending_pixels.push_back({24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF});
        pending_pixels.push_back('0);

        for (int n = 0; n < 1100; n++) begin
            for (int c = 0; c < 3; c++) begin
                kind = $urandom_range(0, 3);
                case (kind)
                    0: chan[c] = $urandom_range(0, 24'hFFFFFF);
                    1: chan[c] = $urandom_range(0, 24'h0FFFFF);
                    2: chan[c] = $urandom_range(0, 24'h01FFFF);
                    default: chan[c] = $urandom_range(0, 24'h000FFF);
                endcase
            end
            pending_pixels.push_back({chan[2], chan[1], chan[0]});
        end
        n_queued = pending_pixels.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_pixels.size() == 0 && n_sent == n_queued && expected_codes.size() == 0);
        repeat (40) @(posedge i_clk);
        $display("sent %0d pixels, checked %0d outputs with random stalls on both sides",
                 n_sent, n_received);
        $display("including full-scale, saturating and near-zero channels and a long hold-off");
        if (n_errors == 0 && expected_codes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("timeout with %0d outputs still expected", expected_codes.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
